/* src/fdaf_pkg.sv */
// Shared types, constants and helper functions of the fixed-point decimal formatter.
`timescale 1ns / 1ps
package fdaf_pkg;

  localparam int VAL_W   = 48;
  localparam int SCALE_W = 14;
  localparam int PROD_W  = VAL_W + SCALE_W;
  localparam int BIN_W   = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_MAX_DIGITS = 10;
  localparam int MAX_DEC = 4;

  localparam logic [63:0] SAT_LIMIT = 64'd4294967295;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_DASH  = 8'h2d;
  localparam logic [7:0] ASCII_POINT = 8'h2e;

  // Configuration register contents.
  typedef struct packed {
    logic [2:0] decimals;
    logic       pad_mode;
    logic [3:0] total_digits;
  } cfg_t;

  // Powers of ten, 10^0 .. 10^10.
  function automatic logic [63:0] pow10(input logic [3:0] k);
    logic [63:0] r;
    unique case (k)
      4'd0:    r = 64'd1;
      4'd1:    r = 64'd10;
      4'd2:    r = 64'd100;
      4'd3:    r = 64'd1000;
      4'd4:    r = 64'd10000;
      4'd5:    r = 64'd100000;
      4'd6:    r = 64'd1000000;
      4'd7:    r = 64'd10000000;
      4'd8:    r = 64'd100000000;
      4'd9:    r = 64'd1000000000;
      default: r = 64'd10000000000;
    endcase
    return r;
  endfunction

  // Effective decimals: clipped to four and to the digit count.
  function automatic logic [3:0] eff_dec(input logic [2:0] d, input logic [3:0] maxd);
    logic [3:0] r;
    r = (d > 3'(MAX_DEC)) ? 4'(MAX_DEC) : {1'b0, d};
    if (r > maxd) r = maxd;
    return r;
  endfunction

  // Effective total digit count of the padded mode.
  function automatic logic [3:0] eff_total(input logic [3:0] t, input logic [3:0] de,
                                           input logic [3:0] maxd);
    logic [3:0] r;
    r = (t == 4'd0) ? 4'd1 : t;
    if (r > maxd) r = maxd;
    if (r < de) r = de;
    return r;
  endfunction

endpackage

/* src/fdaf_scale.sv */
// Three-stage front end: magnitude, decimal scaling multiply, rounding and saturation.
`timescale 1ns / 1ps
module fdaf_scale import fdaf_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BIN_W-1:0]  out_bin,
  output logic              out_neg,
  output logic              out_ovf
);

  localparam logic [3:0]  MAXD = 4'(MAX_DIGITS);
  localparam logic [63:0] LIM_BASE =
    ((pow10(MAXD) - 64'd1) < SAT_LIMIT) ? (pow10(MAXD) - 64'd1) : SAT_LIMIT;

  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3;
  logic [VAL_W-1:0]  mag;
  logic              neg1, neg2, neg3;
  logic [PROD_W-1:0] prod;
  logic [BIN_W-1:0]  bin;
  logic              ovf;

  logic [3:0]        dec_e;
  logic [3:0]        tot_e;
  logic [63:0]       scale_full;
  logic [63:0]       pad_lim;
  logic [63:0]       limit;
  logic [PROD_W:0]   half;
  logic [PROD_W:0]   rnd;
  logic [63:0]       scaled;

  // Stage advance: a stage takes new data when empty or when it drains.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign dec_e = eff_dec(cfg.decimals, MAXD);
  assign tot_e = eff_total(cfg.total_digits, dec_e, MAXD);

  // Scale factor 10^decimals; at most four decimals fit in SCALE_W bits.
  assign scale_full = pow10(dec_e);

  // Rounding half away from zero, then the saturation limit.
  always_comb begin
    pad_lim = pow10(tot_e) - 64'd1;
    limit   = (cfg.pad_mode && (pad_lim < LIM_BASE)) ? pad_lim : LIM_BASE;
    half    = {prod, 1'b0} >> FRAC_BITS;
    rnd     = half + (PROD_W+1)'(1);
    scaled  = 64'(rnd[PROD_W:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      neg1 <= in_value[VAL_W-1];
      mag  <= in_value[VAL_W-1] ? (~in_value + VAL_W'(1)) : in_value;
    end
    if (rdy2 && v1) begin
      neg2 <= neg1;
      prod <= mag * scale_full[SCALE_W-1:0];
    end
    if (rdy3 && v2) begin
      neg3 <= neg2;
      ovf  <= scaled > limit;
      bin  <= (scaled > limit) ? limit[BIN_W-1:0] : scaled[BIN_W-1:0];
    end
  end

  assign out_valid = v3;
  assign out_bin   = bin;
  assign out_neg   = neg3;
  assign out_ovf   = ovf;

endmodule

/* src/fdaf_bcd.sv */
// Four-stage binary to BCD converter, eight shift-and-add-three steps per stage.
`timescale 1ns / 1ps
module fdaf_bcd import fdaf_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BIN_W-1:0]        in_bin,
  input  logic                    in_neg,
  input  logic                    in_ovf,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [4*MAX_DIGITS-1:0] out_bcd,
  output logic                    out_neg,
  output logic                    out_ovf
);

  localparam int BW     = 4 * MAX_DIGITS;
  localparam int NST    = 4;
  localparam int STEPS  = BIN_W / NST;

  logic [NST-1:0]   v;
  logic [NST-1:0]   rdy;
  logic [BIN_W-1:0] bin_q [NST];
  logic [BW-1:0]    bcd_q [NST];
  logic [NST-1:0]   neg_q;
  logic [NST-1:0]   ovf_q;

  // One group of double-dabble steps over the top bits of the binary word.
  function automatic logic [BW+BIN_W-1:0] dabble(input logic [BW-1:0] b,
                                                 input logic [BIN_W-1:0] x);
    logic [BW-1:0]    bb;
    logic [BIN_W-1:0] xx;
    bb = b;
    xx = x;
    for (int s = 0; s < STEPS; s++) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (bb[4*i +: 4] >= 4'd5) bb[4*i +: 4] = bb[4*i +: 4] + 4'd3;
      end
      bb = {bb[BW-2:0], xx[BIN_W-1]};
      xx = {xx[BIN_W-2:0], 1'b0};
    end
    return {bb, xx};
  endfunction

  assign in_ready = rdy[0];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [BW-1:0]    src_bcd;
    logic [BIN_W-1:0] src_bin;
    logic             src_v;
    logic             src_neg;
    logic             src_ovf;
    logic [BW+BIN_W-1:0] res;

    if (k == 0) begin : g_first
      assign src_bcd = '0;
      assign src_bin = in_bin;
      assign src_v   = in_valid;
      assign src_neg = in_neg;
      assign src_ovf = in_ovf;
    end else begin : g_next
      assign src_bcd = bcd_q[k-1];
      assign src_bin = bin_q[k-1];
      assign src_v   = v[k-1];
      assign src_neg = neg_q[k-1];
      assign src_ovf = ovf_q[k-1];
    end

    if (k == NST-1) begin : g_last_rdy
      assign rdy[k] = !v[k] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end

    assign res = dabble(src_bcd, src_bin);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        bcd_q[k] <= res[BW+BIN_W-1:BIN_W];
        bin_q[k] <= res[BIN_W-1:0];
        neg_q[k] <= src_neg;
        ovf_q[k] <= src_ovf;
      end
    end
  end

  assign out_valid = v[NST-1];
  assign out_bcd   = bcd_q[NST-1];
  assign out_neg   = neg_q[NST-1];
  assign out_ovf   = ovf_q[NST-1];

endmodule

/* src/fdaf_emit.sv */
// String layout stage and character serializer.
`timescale 1ns / 1ps
module fdaf_emit import fdaf_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [4*MAX_DIGITS-1:0] in_bcd,
  input  logic                    in_neg,
  input  logic                    in_ovf,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last,
  output logic                    out_ovf
);

  localparam logic [3:0] MAXD = 4'(MAX_DIGITS);
  localparam int BW = 4 * MAX_DIGITS;

  logic [3:0] dec_e;
  logic [3:0] tot_e;

  // Layout stage registers.
  logic          lv;
  logic [BW-1:0] l_bcd;
  logic          l_neg;
  logic          l_ovf;
  logic [3:0]    l_width;
  logic [3:0]    l_n;

  // Serializer registers.
  logic          busy;
  logic [BW-1:0] s_bcd;
  logic          s_neg;
  logic          s_ovf;
  logic [3:0]    s_width;
  logic [3:0]    s_n;
  logic [3:0]    pos;

  logic          load;
  logic          done;
  logic [3:0]    top;
  logic          found;
  logic [3:0]    width;
  logic [3:0]    q;
  logic [3:0]    idx;
  logic [3:0]    dval;
  logic          is_digit;

  assign dec_e = eff_dec(cfg.decimals, MAXD);
  assign tot_e = eff_total(cfg.total_digits, dec_e, MAXD);

  // Width of the integer part: padded width, or the significant digits.
  always_comb begin
    top   = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (in_bcd[4*i +: 4] != 4'd0) begin
        top   = 4'(i);
        found = 1'b1;
      end
    end
    if (cfg.pad_mode) begin
      width = (tot_e == dec_e) ? 4'd1 : (tot_e - dec_e);
    end else begin
      width = (found && (top >= dec_e)) ? (top - dec_e + 4'd1) : 4'd1;
    end
  end

  assign done     = busy && out_ready && (pos == s_n - 4'd1);
  assign load     = !busy || done;
  assign in_ready = !lv || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv   <= 1'b0;
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (in_ready) lv <= in_valid;
      if (load) begin
        busy <= lv;
        pos  <= '0;
      end else if (busy && out_ready) begin
        pos <= pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      l_bcd   <= in_bcd;
      l_neg   <= in_neg;
      l_ovf   <= in_ovf;
      l_width <= width;
      l_n     <= 4'(in_neg) + width + ((dec_e != 4'd0) ? (dec_e + 4'd1) : 4'd0);
    end
    if (load && lv) begin
      s_bcd   <= l_bcd;
      s_neg   <= l_neg;
      s_ovf   <= l_ovf;
      s_width <= l_width;
      s_n     <= l_n;
    end
  end

  // Character at the current position: sign, integer digits, point, fraction.
  always_comb begin
    q        = pos - 4'(s_neg);
    is_digit = 1'b0;
    idx      = '0;
    if (q < s_width) begin
      is_digit = 1'b1;
      idx      = dec_e + s_width - 4'd1 - q;
    end else if (q != s_width) begin
      is_digit = 1'b1;
      idx      = dec_e + s_width - q;
    end
    dval = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (idx == 4'(i)) dval = s_bcd[4*i +: 4];
    end
    if (s_neg && pos == 4'd0) begin
      out_char = ASCII_DASH;
    end else if (is_digit) begin
      out_char = ASCII_ZERO + {4'd0, dval};
    end else begin
      out_char = ASCII_POINT;
    end
  end

  assign out_valid = busy;
  assign out_last  = (pos == s_n - 4'd1);
  assign out_ovf   = s_ovf;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos < s_n))
    else $error("character position beyond string length");
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    busy |-> (out_char == ASCII_DASH || out_char == ASCII_POINT ||
              (out_char >= ASCII_ZERO && out_char <= ASCII_NINE)))
    else $error("character outside the output alphabet");
  a_dash_first: assert property (@(posedge clk) disable iff (rst)
    (busy && out_char == ASCII_DASH) |-> (pos == 4'd0))
    else $error("sign not in first position");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && !out_last) |=> (busy && pos == $past(pos) + 4'd1))
    else $error("serializer did not advance to the next character");
`endif

endmodule

/* src/fixed_decimal_ascii_formatter_unit.sv */
// Top level of the fixed-point decimal ASCII formatter with its register port.
`timescale 1ns / 1ps
// Converts signed fixed-point values (FRAC_BITS fraction bits) to ASCII
// decimal strings, one character per output transaction, with tlast on the
// final character and tuser set on every character of a saturated value.
// A value produces one to twelve characters, and the character serializer
// at the output emits one per cycle while m_tready is high; a new value may
// enter every cycle while the serializer is busy, up to the eight pipeline
// stages ahead of it (magnitude, multiply, round/saturate, four BCD stages,
// layout). Registers: decimals at 0x0, pad_mode at 0x4, total_digits at
// 0x8; write them only while the block is idle.
module fixed_decimal_ascii_formatter_unit import fdaf_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,   // [47:0] value
  // Output stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] character
  output logic              m_tlast,
  output logic              m_tuser    // [0] overflow
);

  localparam logic [1:0] REG_DECIMALS = 2'd0;
  localparam logic [1:0] REG_PAD_MODE = 2'd1;
  localparam logic [1:0] REG_TOTAL    = 2'd2;

  cfg_t cfg;

  logic             sc_valid, sc_ready;
  logic [BIN_W-1:0] sc_bin;
  logic             sc_neg, sc_ovf;
  logic             bc_valid, bc_ready;
  logic [4*MAX_DIGITS-1:0] bc_bcd;
  logic             bc_neg, bc_ovf;

  assign pready = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decimals     <= 3'd0;
      cfg.pad_mode     <= 1'b0;
      cfg.total_digits <= 4'd10;
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        REG_DECIMALS: cfg.decimals     <= pwdata[2:0];
        REG_PAD_MODE: cfg.pad_mode     <= pwdata[0];
        REG_TOTAL:    cfg.total_digits <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_DECIMALS: prdata = {29'd0, cfg.decimals};
      REG_PAD_MODE: prdata = {31'd0, cfg.pad_mode};
      REG_TOTAL:    prdata = {28'd0, cfg.total_digits};
      default:      prdata = 32'd0;
    endcase
  end

  fdaf_scale #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (s_tdata),
    .out_valid(sc_valid),
    .out_ready(sc_ready),
    .out_bin  (sc_bin),
    .out_neg  (sc_neg),
    .out_ovf  (sc_ovf)
  );

  fdaf_bcd #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_bcd (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sc_valid),
    .in_ready (sc_ready),
    .in_bin   (sc_bin),
    .in_neg   (sc_neg),
    .in_ovf   (sc_ovf),
    .out_valid(bc_valid),
    .out_ready(bc_ready),
    .out_bcd  (bc_bcd),
    .out_neg  (bc_neg),
    .out_ovf  (bc_ovf)
  );

  fdaf_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (bc_valid),
    .in_ready (bc_ready),
    .in_bcd   (bc_bcd),
    .in_neg   (bc_neg),
    .in_ovf   (bc_ovf),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_char (m_tdata),
    .out_last (m_tlast),
    .out_ovf  (m_tuser)
  );

endmodule
